[rtl/core/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, status codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HeapBytes     = 102400;
  localparam int unsigned GranuleBytes  = 16;
  localparam int unsigned GranShift     = $clog2(GranuleBytes);
  localparam int unsigned NumGran       = HeapBytes / GranuleBytes;
  localparam int unsigned HeaderGran    = (24 + GranuleBytes - 1) / GranuleBytes;
  localparam int unsigned HeaderBytes   = HeaderGran * GranuleBytes;
  localparam int unsigned GranW         = $clog2(NumGran + 1);
  localparam int unsigned EndW          = GranW + 1;
  localparam int unsigned MaxExt        = 64;
  localparam int unsigned ExtAw         = $clog2(MaxExt);
  localparam int unsigned CntW          = ExtAw + 1;
  localparam int unsigned RecAw         = $clog2(NumGran);
  localparam int unsigned BytesW        = 17;
  localparam int unsigned NeedW         = 32 - GranShift + 2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNull     = 3'd1;
  localparam logic [2:0] StNoFit    = 3'd2;
  localparam logic [2:0] StBadPtr   = 3'd3;
  localparam logic [2:0] StNotAlloc = 3'd4;
  localparam logic [2:0] StOverlap  = 3'd5;
  localparam logic [2:0] StFull     = 3'd6;

  localparam logic KindAlloc = 1'b0;

  typedef struct packed {
    logic [GranW-1:0] start;
    logic [GranW-1:0] len;
  } ext_t;

  typedef struct packed {
    logic             is_null;
    logic             too_big;
    logic             bad_ptr;
    logic [GranW-1:0] need;
    logic [RecAw-1:0] hdr;
  } dec_t;

endpackage

[rtl/core/ffha_decode.sv]
// ----------------------------------------------------------------------------
// ffha_decode
// Request pre-check: granule need of an allocate, pointer checks of a free.
// ----------------------------------------------------------------------------
module ffha_decode (
  input  logic [31:0]     request_bytes_i,
  input  logic [63:0]     payload_address_i,
  input  logic            kind_i,
  input  logic [63:0]     heap_base_i,
  output ffha_pkg::dec_t  dec_o
);
  import ffha_pkg::*;

  logic [32:0]      req_up;
  logic [NeedW-1:0] need_full;
  logic [63:0]      off;
  logic [63:0]      off_hdr;

  always_comb begin
    req_up    = {1'b0, request_bytes_i} + 33'(GranuleBytes - 1);
    need_full = NeedW'(req_up >> GranShift) + NeedW'(HeaderGran);
    off       = payload_address_i - heap_base_i;
    off_hdr   = off - 64'(HeaderBytes);
    dec_o.need    = need_full[GranW-1:0];
    dec_o.too_big = need_full > NeedW'(NumGran);
    dec_o.is_null = (kind_i == KindAlloc) ? (request_bytes_i == 32'd0)
                                          : (payload_address_i == 64'd0);
    dec_o.bad_ptr = (off[GranShift-1:0] != '0) || (off < 64'(HeaderBytes)) ||
                    (off >= 64'(HeapBytes));
    dec_o.hdr     = RecAw'(off_hdr >> GranShift);
  end

endmodule

[rtl/core/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit, address-ordered free-list allocator over a granule heap.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  in      | in_valid_i/in_ready_o, kind, req, ptr | request in
//  out     | out_valid_o/out_ready_i, status, ...  | result out
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_data_i   | heap_base write
//
// The extent table has one read port, so the first-fit or insert-point scan
// reads one free extent a cycle, and removing or inserting an extent moves one
// entry a cycle.
// After reset a clearing pass zeroes all 6400 block records; no
// request is taken meanwhile. A stalled result holds in the output register
// while the next request is taken.
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] request_bytes_i,
  input  logic [63:0] payload_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] result_address_o,
  output logic [16:0] block_bytes_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);
  import ffha_pkg::*;

  localparam logic [3:0] SClear  = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SChk    = 4'd2;
  localparam logic [3:0] SRec    = 4'd3;
  localparam logic [3:0] SScan   = 4'd4;
  localparam logic [3:0] SDecide = 4'd5;
  localparam logic [3:0] SShift  = 4'd6;
  localparam logic [3:0] SFinal  = 4'd7;
  localparam logic [3:0] SResp   = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [63:0]       base_q;
  logic              kind_q;
  logic [31:0]       req_q;
  logic [63:0]       ptr_q;
  dec_t              dec;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [RecAw-1:0]  clr_q, clr_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [ExtAw-1:0]  pend_q, pend_d;
  logic              pv_q, pv_d;
  logic              found_q, found_d;
  logic [CntW-1:0]   p_q, p_d;
  ext_t              cur_q, cur_d;
  ext_t              prev_q, prev_d;
  logic              hprev_q, hprev_d;
  logic [GranW-1:0]  len_q, len_d;
  logic [CntW-1:0]   src_q, src_d;
  logic [CntW-1:0]   wa_q, wa_d;
  logic [CntW-1:0]   n_q, n_d;
  logic              up_q, up_d;
  logic              sv_q, sv_d;
  logic              ins_q, ins_d;
  logic [2:0]        st_q, st_d;
  logic [63:0]       ra_q, ra_d;
  logic [BytesW-1:0] bb_q, bb_d;
  logic              ov_q, ov_d;
  logic [2:0]        ost_q, ost_d;
  logic [63:0]       ora_q, ora_d;
  logic [BytesW-1:0] obb_q, obb_d;

  // extent table and block records
  ext_t              ext_mem [MaxExt];
  ext_t              ext_rdata;
  logic [ExtAw-1:0]  ext_raddr, ext_waddr;
  logic              ext_we;
  ext_t              ext_wdata;
  logic [GranW-1:0]  rec_mem [NumGran];
  logic [GranW-1:0]  rec_rdata;
  logic              rec_we;
  logic [RecAw-1:0]  rec_waddr;
  logic [GranW-1:0]  rec_wdata;

  logic              fit;
  logic [EndW-1:0]   prev_end, blk_end;
  logic              jp, jn;

  ffha_decode u_dec (
    .request_bytes_i   (req_q),
    .payload_address_i (ptr_q),
    .kind_i            (kind_q),
    .heap_base_i       (base_q),
    .dec_o             (dec)
  );

  always_ff @(posedge clk_i) begin
    if (ext_we) begin
      ext_mem[ext_waddr] <= ext_wdata;
    end
    ext_rdata <= ext_mem[ext_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rdata <= rec_mem[dec.hdr];
  end

  assign in_ready_o       = (state_q == SIdle);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = ov_q;
  assign status_o         = ost_q;
  assign result_address_o = ora_q;
  assign block_bytes_o    = obb_q;

  always_comb begin
    fit      = (kind_q == KindAlloc) ? (ext_rdata.len >= dec.need)
                                     : (ext_rdata.start >= GranW'(dec.hdr));
    prev_end = EndW'(prev_q.start) + EndW'(prev_q.len);
    blk_end  = EndW'(dec.hdr) + EndW'(len_q);
    jp       = hprev_q && (prev_end == EndW'(dec.hdr));
    jn       = found_q && (blk_end == EndW'(cur_q.start));
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    pv_d    = 1'b0;
    found_d = found_q;
    p_d     = p_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    hprev_d = hprev_q;
    len_d   = len_q;
    src_d   = src_q;
    wa_d    = wa_q;
    n_d     = n_q;
    up_d    = up_q;
    sv_d    = 1'b0;
    ins_d   = ins_q;
    st_d    = st_q;
    ra_d    = 64'd0;
    bb_d    = '0;
    ra_d    = ra_q;
    bb_d    = bb_q;
    ext_raddr = idx_q[ExtAw-1:0];
    ext_we    = 1'b0;
    ext_waddr = '0;
    ext_wdata = '0;
    rec_we    = 1'b0;
    rec_waddr = clr_q;
    rec_wdata = '0;
    ov_d  = ov_q && !out_ready_i;
    ost_d = ost_q;
    ora_d = ora_q;
    obb_d = obb_q;

    case (state_q)
      SClear: begin
        rec_we = 1'b1;
        if (clr_q == '0) begin
          ext_we    = 1'b1;
          ext_wdata = '{start: '0, len: GranW'(NumGran)};
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == RecAw'(NumGran - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          state_d = SChk;
        end
      end
      SChk: begin
        st_d    = StOk;
        ra_d    = 64'd0;
        bb_d    = '0;
        idx_d   = '0;
        hprev_d = 1'b0;
        ins_d   = 1'b0;
        if (dec.is_null) begin
          st_d    = StNull;
          state_d = SResp;
        end else if (kind_q == KindAlloc) begin
          if (dec.too_big) begin
            st_d    = StNoFit;
            state_d = SResp;
          end else begin
            state_d = SScan;
          end
        end else if (dec.bad_ptr) begin
          st_d    = StBadPtr;
          state_d = SResp;
        end else begin
          state_d = SRec;
        end
      end
      SRec: begin
        len_d = rec_rdata;
        if (rec_rdata == '0) begin
          st_d    = StNotAlloc;
          state_d = SResp;
        end else begin
          state_d = SScan;
        end
      end
      SScan: begin
        if (idx_q < cnt_q) begin
          pv_d   = 1'b1;
          pend_d = idx_q[ExtAw-1:0];
          idx_d  = idx_q + 1'b1;
        end
        if (pv_q && fit) begin
          found_d = 1'b1;
          p_d     = CntW'(pend_q);
          cur_d   = ext_rdata;
          pv_d    = 1'b0;
          state_d = SDecide;
        end else begin
          if (pv_q) begin
            prev_d  = ext_rdata;
            hprev_d = 1'b1;
          end
          if (!pv_q && (idx_q >= cnt_q)) begin
            found_d = 1'b0;
            p_d     = cnt_q;
            state_d = SDecide;
          end
        end
      end
      SDecide: begin
        state_d = SShift;
        up_d    = 1'b0;
        n_d     = '0;
        if (kind_q == KindAlloc) begin
          if (!found_q) begin
            st_d    = StNoFit;
            state_d = SResp;
          end else if (cur_q.len == dec.need) begin
            src_d = p_q + 1'b1;
            n_d   = cnt_q - p_q - 1'b1;
            cnt_d = cnt_q - 1'b1;
          end else begin
            ext_we    = 1'b1;
            ext_waddr = p_q[ExtAw-1:0];
            ext_wdata = '{start: cur_q.start + dec.need, len: cur_q.len - dec.need};
          end
        end else if ((hprev_q && (prev_end > EndW'(dec.hdr))) ||
                     (found_q && (blk_end > EndW'(cur_q.start)))) begin
          st_d    = StOverlap;
          state_d = SResp;
        end else if (jp && jn) begin
          ext_we    = 1'b1;
          ext_waddr = ExtAw'(p_q - 1'b1);
          ext_wdata = '{start: prev_q.start, len: prev_q.len + len_q + cur_q.len};
          src_d     = p_q + 1'b1;
          n_d       = cnt_q - p_q - 1'b1;
          cnt_d     = cnt_q - 1'b1;
        end else if (jp) begin
          ext_we    = 1'b1;
          ext_waddr = ExtAw'(p_q - 1'b1);
          ext_wdata = '{start: prev_q.start, len: prev_q.len + len_q};
        end else if (jn) begin
          ext_we    = 1'b1;
          ext_waddr = p_q[ExtAw-1:0];
          ext_wdata = '{start: GranW'(dec.hdr), len: cur_q.len + len_q};
        end else if (cnt_q >= CntW'(MaxExt)) begin
          st_d    = StFull;
          state_d = SResp;
        end else begin
          up_d  = 1'b1;
          ins_d = 1'b1;
          src_d = cnt_q - 1'b1;
          n_d   = cnt_q - p_q;
          cnt_d = cnt_q + 1'b1;
        end
      end
      SShift: begin
        // one entry read per cycle, written to its neighbour the cycle after
        ext_raddr = src_q[ExtAw-1:0];
        if (n_q != '0) begin
          sv_d  = 1'b1;
          wa_d  = up_q ? (src_q + 1'b1) : (src_q - 1'b1);
          src_d = up_q ? (src_q - 1'b1) : (src_q + 1'b1);
          n_d   = n_q - 1'b1;
        end
        if (sv_q) begin
          ext_we    = 1'b1;
          ext_waddr = wa_q[ExtAw-1:0];
          ext_wdata = ext_rdata;
        end
        if ((n_q == '0) && !sv_q) begin
          state_d = SFinal;
        end
      end
      SFinal: begin
        rec_we = 1'b1;
        st_d   = StOk;
        if (kind_q == KindAlloc) begin
          rec_waddr = RecAw'(cur_q.start);
          rec_wdata = dec.need;
          ra_d = base_q + 64'({cur_q.start, GranShift'(0)}) + 64'(HeaderBytes);
          bb_d = BytesW'({dec.need, GranShift'(0)});
        end else begin
          rec_waddr = dec.hdr;
          rec_wdata = '0;
          bb_d      = BytesW'({len_q, GranShift'(0)});
          if (ins_q) begin
            ext_we    = 1'b1;
            ext_waddr = p_q[ExtAw-1:0];
            ext_wdata = '{start: GranW'(dec.hdr), len: len_q};
          end
        end
        state_d = SResp;
      end
      SResp: begin
        // hold until the output register is free
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ost_d   = st_q;
          ora_d   = ra_q;
          obb_d   = bb_q;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      base_q  <= 64'hffffc00000000000;
      cnt_q   <= CntW'(1);
      clr_q   <= '0;
      pv_q    <= 1'b0;
      sv_q    <= 1'b0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      pv_q    <= pv_d;
      sv_q    <= sv_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      req_q  <= request_bytes_i;
      ptr_q  <= payload_address_i;
    end
    idx_q   <= idx_d;
    pend_q  <= pend_d;
    found_q <= found_d;
    p_q     <= p_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    hprev_q <= hprev_d;
    len_q   <= len_d;
    src_q   <= src_d;
    wa_q    <= wa_d;
    up_q    <= up_d;
    ins_q   <= ins_d;
    st_q    <= st_d;
    ra_q    <= ra_d;
    bb_q    <= bb_d;
    ost_q   <= ost_d;
    ora_q   <= ora_d;
    obb_q   <= obb_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxExt))
    else $error("free extent count beyond table depth");

  a_shift_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SShift && n_q != '0) |=> (n_q == $past(n_q) - 1'b1))
    else $error("extent move counter did not advance");

  a_ok_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SResp && st_q == StOk) |-> (bb_q != '0))
    else $error("successful request with zero block size");

  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SClear) |=> (state_q == SClear || state_q == SIdle))
    else $error("request work started during clearing pass");

endmodule

[test/first_fit_heap_allocator_tb.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate and free requests into the allocator under random stalls on
// both channels, predicts every result from a model of the free-extent table
// and the block records, and compares status, address and size field by field.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] addr;
    logic [16:0] nbytes;
  } heap_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [31:0] request_bytes_i = '0;
  logic [63:0] payload_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] result_address_o;
  logic [16:0] block_bytes_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i = '0;

  first_fit_heap_allocator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .request_bytes_i,
    .payload_address_i, .out_valid_o, .out_ready_i, .status_o, .result_address_o,
    .block_bytes_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #300ms;
    $display("Mismatches found");
    $finish;
  end

  // model state
  logic [63:0]    heap_base_m;
  int unsigned    ext_start[MaxExt];
  int unsigned    ext_len[MaxExt];
  int unsigned    ext_count;
  int unsigned    block_len[NumGran];
  heap_result_t   pending_results[$];
  logic [63:0]    live_ptrs[$];
  int             n_errors = 0;
  bit             idle_on = 1'b1;
  int             rx_hold = 0;

  function automatic void reset_heap_model();
    ext_count = 1;
    ext_start[0] = 0;
    ext_len[0] = NumGran;
    foreach (block_len[i]) block_len[i] = 0;
  endfunction

  function automatic void drop_extent(int unsigned i);
    for (int unsigned k = i; k + 1 < ext_count; k++) begin
      ext_start[k] = ext_start[k+1];
      ext_len[k] = ext_len[k+1];
    end
    ext_count--;
  endfunction

  function automatic heap_result_t predict_allocate(logic [31:0] req);
    heap_result_t r = '{StOk, '0, '0};
    longint unsigned need;
    int unsigned i, s;
    if (req == 0) begin
      r.status = StNull;
      return r;
    end
    need = HeaderGran + (longint'(req) + GranuleBytes - 1) / GranuleBytes;
    if (need > NumGran) begin
      r.status = StNoFit;
      return r;
    end
    for (i = 0; i < ext_count; i++) if (ext_len[i] >= need) break;
    if (i >= ext_count) begin
      r.status = StNoFit;
      return r;
    end
    s = ext_start[i];
    if (ext_len[i] == need) drop_extent(i);
    else begin
      ext_start[i] = s + need;
      ext_len[i] -= need;
    end
    block_len[s] = need;
    r.addr = heap_base_m + 64'(s) * GranuleBytes + HeaderBytes;
    r.nbytes = 17'(need * GranuleBytes);
    live_ptrs.push_back(r.addr);
    return r;
  endfunction

  function automatic heap_result_t predict_free(logic [63:0] addr);
    heap_result_t r = '{StOk, '0, '0};
    logic [63:0] off;
    int unsigned h, len, e, p;
    bit has_prev, has_next, join_prev, join_next;
    if (addr == 0) begin
      r.status = StNull;
      return r;
    end
    off = addr - heap_base_m;
    if (off % GranuleBytes != 0 || off < HeaderBytes || off >= HeapBytes) begin
      r.status = StBadPtr;
      return r;
    end
    h = (off - HeaderBytes) / GranuleBytes;
    len = block_len[h];
    if (len == 0) begin
      r.status = StNotAlloc;
      return r;
    end
    e = h + len;
    for (p = 0; p < ext_count && ext_start[p] < h; p++) ;
    has_prev = p > 0;
    has_next = p < ext_count;
    if ((has_prev && ext_start[p-1] + ext_len[p-1] > h) ||
        (has_next && e > ext_start[p])) begin
      r.status = StOverlap;
      return r;
    end
    join_prev = has_prev && ext_start[p-1] + ext_len[p-1] == h;
    join_next = has_next && e == ext_start[p];
    if (join_prev && join_next) begin
      ext_len[p-1] += len + ext_len[p];
      drop_extent(p);
    end else if (join_prev) begin
      ext_len[p-1] += len;
    end else if (join_next) begin
      ext_start[p] = h;
      ext_len[p] += len;
    end else begin
      if (ext_count >= MaxExt) begin
        r.status = StFull;
        return r;
      end
      for (int unsigned k = ext_count; k > p; k--) begin
        ext_start[k] = ext_start[k-1];
        ext_len[k] = ext_len[k-1];
      end
      ext_start[p] = h;
      ext_len[p] = len;
      ext_count++;
    end
    block_len[h] = 0;
    foreach (live_ptrs[i]) if (live_ptrs[i] == addr) begin
      live_ptrs.delete(i);
      break;
    end
    r.nbytes = 17'(len * GranuleBytes);
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    heap_result_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status_o);
          n_errors++;
        end
        if (result_address_o !== exp_r.addr) begin
          $error("result_address expected %h actual %h", exp_r.addr, result_address_o);
          n_errors++;
        end
        if (block_bytes_o !== exp_r.nbytes) begin
          $error("block_bytes expected %0d actual %0d", exp_r.nbytes, block_bytes_o);
          n_errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rx_hold = $urandom_range(1, 18) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // valid stays high after an accept only until the next call or a drain,
  // both within the same time step
  task automatic send_request(logic kind, logic [31:0] req, logic [63:0] addr);
    heap_result_t r;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    request_bytes_i <= req;
    payload_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    r = (kind == KindAlloc) ? predict_allocate(req) : predict_free(addr);
    pending_results.push_back(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_heap_base(logic [63:0] base);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    heap_base_m = base;
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(1, 16384);
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  function automatic logic [63:0] pick_free_ptr();
    int unsigned c = $urandom_range(0, 19);
    if (live_ptrs.size() != 0 && c < 15)
      return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
    case (c)
      15:      return '0;
      16:      return {$urandom, $urandom};
      17:      return heap_base_m + 16 * $urandom_range(0, HeapBytes / 16 + 4);
      default: return heap_base_m + HeaderBytes + 16 * $urandom_range(0, NumGran - 3);
    endcase
  endfunction

  // a block refused for a full table goes to the back and is retried later
  task automatic free_everything();
    logic [63:0] ptr;
    while (live_ptrs.size() != 0) begin
      ptr = live_ptrs[0];
      send_request(1'b1, '0, ptr);
      if (live_ptrs.size() != 0 && live_ptrs[0] == ptr) begin
        void'(live_ptrs.pop_front());
        live_ptrs.push_back(ptr);
      end
    end
  endtask

  task automatic test_directed();
    send_request(KindAlloc, 32'd0, '0);
    send_request(KindAlloc, 32'hFFFF_FFFF, '0);
    send_request(KindAlloc, 32'd102368, '0);
    send_request(1'b1, '0, heap_base_m + HeaderBytes);
    send_request(KindAlloc, 32'd102369, '0);
    send_request(KindAlloc, 32'd1, '0);
    send_request(KindAlloc, 32'd17, '0);
    send_request(KindAlloc, 32'd100, '0);
    send_request(1'b1, '0, '0);
    send_request(1'b1, '0, heap_base_m + 40);
    send_request(1'b1, '0, heap_base_m + 16);
    send_request(1'b1, '0, heap_base_m + HeapBytes);
    send_request(1'b1, '0, 64'hFFFF_FFFF_FFFF_FFF0);
    send_request(1'b1, '0, heap_base_m + 48 + 32);
    send_request(1'b1, '0, heap_base_m + 32);
    send_request(1'b1, '0, heap_base_m + 32);
    send_request(1'b1, '0, heap_base_m + 96 + 32);
    send_request(1'b1, '0, heap_base_m + 48 + 32);
    send_request(KindAlloc, 32'd0, '0);
    free_everything();
  endtask

  // fill the table with isolated holes until it overflows
  task automatic test_table_full();
    logic [63:0] ptrs[$];
    for (int i = 0; i < 140; i++) begin
      send_request(KindAlloc, 32'd16, '0);
      ptrs.push_back(live_ptrs[$]);
    end
    for (int i = 0; i < 140; i += 2) send_request(1'b1, '0, ptrs[i]);
    free_everything();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) send_request(KindAlloc, pick_size(), '0);
      else send_request(1'b1, '0, pick_free_ptr());
    end
  endtask

  // stall the receiver long enough for the input to back up
  task automatic test_backpressure();
    rx_hold = 400;
    test_random(20);
    drain();
  endtask

  initial begin
    heap_base_m = 64'hFFFF_C000_0000_0000;
    reset_heap_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_table_full();
    test_random(250);
    test_backpressure();
    free_everything();
    write_heap_base(64'h0);
    test_directed();
    test_random(150);
    free_everything();
    write_heap_base(64'hFFFF_FFFF_FFFF_FFF0);
    test_directed();
    test_random(150);
    free_everything();
    write_heap_base({$urandom, $urandom_range(0, 32'hFFFF) << 4});
    test_random(100);
    idle_on = 1'b0;
    test_random(100);
    drain();
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

[files.f]
rtl/core/ffha_pkg.sv
rtl/core/ffha_decode.sv
rtl/core/first_fit_heap_allocator.sv
test/first_fit_heap_allocator_tb.sv
